>>> design/rdpq_pkg.sv
package rdpq_pkg;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } rdpq_in_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic [15:0] screen_red;
    logic [15:0] screen_green;
    logic [15:0] screen_blue;
  } rdpq_out_t;

  // depth modes; codes 6 and 7 fall through to the packed 24-bit path
  typedef enum logic [2:0] {
    MODE_MONO   = 3'd0,
    MODE_FOUR   = 3'd1,
    MODE_EIGHT  = 3'd2,
    MODE_RGB15  = 3'd3,
    MODE_RGB16  = 3'd4,
    MODE_RGB24  = 3'd5
  } rdpq_mode_t;

  localparam int DepthW = 3;

  // standard palette indices
  localparam logic [7:0] IX_WHITE    = 8'd0;
  localparam logic [7:0] IX_BLACK    = 8'd1;
  localparam logic [7:0] IX_RED      = 8'd2;
  localparam logic [7:0] IX_GREEN    = 8'd3;
  localparam logic [7:0] IX_BLUE     = 8'd4;
  localparam logic [7:0] IX_CYAN     = 8'd5;
  localparam logic [7:0] IX_YELLOW   = 8'd6;
  localparam logic [7:0] IX_MAGENTA  = 8'd7;
  localparam logic [7:0] IX_LWHITE   = 8'd8;
  localparam logic [7:0] IX_LBLACK   = 8'd9;
  localparam logic [7:0] IX_LRED     = 8'd10;
  localparam logic [7:0] IX_LGREEN   = 8'd11;
  localparam logic [7:0] IX_LBLUE    = 8'd12;
  localparam logic [7:0] IX_LCYAN    = 8'd13;
  localparam logic [7:0] IX_LYELLOW  = 8'd14;
  localparam logic [7:0] IX_LMAGENTA = 8'd15;

  localparam logic [15:0] LVL_FULL = 16'hFFFF;
  localparam logic [15:0] LVL_HALF = 16'h8000;
  localparam logic [15:0] LVL_ZERO = 16'h0000;

  localparam logic [17:0] MONO_THRESH  = 18'd98302;
  localparam logic [17:0] GREY_MID     = 18'h17FFE;
  localparam logic [17:0] GREY_LOW     = 18'h0BFFF;
  localparam logic [17:0] GREY_HIGH    = 18'h23FFE;
  localparam logic [15:0] GREY_SPREAD  = 16'd3072;
  localparam logic [7:0]  CUBE_BASE    = 8'd15;

  function automatic rdpq_out_t rdpq_make(logic [7:0] pix, logic [15:0] r, logic [15:0] g,
                                          logic [15:0] b);
    rdpq_out_t o;
    o.pixel_value  = {16'd0, pix};
    o.screen_red   = r;
    o.screen_green = g;
    o.screen_blue  = b;
    return o;
  endfunction

  function automatic logic [7:0] rdpq_grey_pix(logic [4:0] i);
    logic [7:0] p;
    case (i)
      5'd0:  p = 8'd1;
      5'd1:  p = 8'd244;
      5'd2:  p = 8'd243;
      5'd3:  p = 8'd255;
      5'd4:  p = 8'd245;
      5'd5:  p = 8'd236;
      5'd6:  p = 8'd58;
      5'd7:  p = 8'd246;
      5'd8:  p = 8'd242;
      5'd9:  p = 8'd254;
      5'd10: p = 8'd247;
      5'd11: p = 8'd249;
      5'd12: p = 8'd101;
      5'd13: p = 8'd241;
      5'd14: p = 8'd235;
      5'd15: p = 8'd240;
      5'd16: p = 8'd239;
      5'd17: p = 8'd248;
      5'd18: p = 8'd238;
      5'd19: p = 8'd144;
      5'd20: p = 8'd234;
      5'd21: p = 8'd237;
      5'd22: p = 8'd253;
      5'd23: p = 8'd252;
      5'd24: p = 8'd233;
      5'd25: p = 8'd187;
      5'd26: p = 8'd232;
      5'd27: p = 8'd231;
      5'd28: p = 8'd251;
      5'd29: p = 8'd250;
      5'd30: p = 8'd230;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] rdpq_cube_level(logic [2:0] q);
    logic [15:0] l;
    case (q)
      3'd0: l = 16'h0000;
      3'd1: l = 16'h3131;
      3'd2: l = 16'h6363;
      3'd3: l = 16'h9C9C;
      3'd4: l = 16'hCECE;
      default: l = 16'hFFFF;
    endcase
    return l;
  endfunction

endpackage

>>> design/rdpq_four.sv
module rdpq_four (
  input  logic [15:0]       r,
  input  logic [15:0]       g,
  input  logic [15:0]       b,
  input  logic [17:0]       sum,
  output rdpq_pkg::rdpq_out_t res
);
  import rdpq_pkg::*;

  logic [5:0] key;

  assign key = {r[15:14], g[15:14], b[15:14]};

  always_comb begin
    case (key)
      6'b11_00_00, 6'b11_00_01, 6'b11_01_00, 6'b11_01_01:
        res = rdpq_make(IX_RED, LVL_FULL, LVL_ZERO, LVL_ZERO);
      6'b10_00_00, 6'b01_00_00:
        res = rdpq_make(IX_LRED, LVL_HALF, LVL_ZERO, LVL_ZERO);
      6'b00_11_00, 6'b00_11_01, 6'b01_11_00, 6'b01_11_01:
        res = rdpq_make(IX_GREEN, LVL_ZERO, LVL_FULL, LVL_ZERO);
      6'b00_10_00, 6'b00_01_00:
        res = rdpq_make(IX_LGREEN, LVL_ZERO, LVL_HALF, LVL_ZERO);
      6'b00_00_11, 6'b00_01_11, 6'b01_00_11, 6'b01_01_11:
        res = rdpq_make(IX_BLUE, LVL_ZERO, LVL_ZERO, LVL_FULL);
      6'b00_00_10, 6'b00_00_01:
        res = rdpq_make(IX_LBLUE, LVL_ZERO, LVL_ZERO, LVL_HALF);
      6'b11_11_00, 6'b11_10_00, 6'b10_11_00, 6'b11_11_01:
        res = rdpq_make(IX_YELLOW, LVL_FULL, LVL_FULL, LVL_ZERO);
      6'b10_10_00, 6'b10_01_00, 6'b01_10_00, 6'b01_01_00:
        res = rdpq_make(IX_LYELLOW, LVL_HALF, LVL_HALF, LVL_ZERO);
      6'b11_00_11, 6'b11_00_10, 6'b10_00_11, 6'b11_01_11:
        res = rdpq_make(IX_MAGENTA, LVL_FULL, LVL_ZERO, LVL_FULL);
      6'b10_00_10, 6'b10_00_01, 6'b01_00_10, 6'b01_00_01:
        res = rdpq_make(IX_LMAGENTA, LVL_HALF, LVL_ZERO, LVL_HALF);
      6'b00_11_11, 6'b00_11_10, 6'b00_10_11, 6'b01_11_11:
        res = rdpq_make(IX_CYAN, LVL_ZERO, LVL_FULL, LVL_FULL);
      6'b00_10_10, 6'b00_10_01, 6'b00_01_10, 6'b00_01_01:
        res = rdpq_make(IX_LCYAN, LVL_ZERO, LVL_HALF, LVL_HALF);
      default: begin
        // no hue stands out: four grey steps by brightness
        if (sum <= GREY_MID) begin
          if (sum <= GREY_LOW) res = rdpq_make(IX_BLACK, 16'h3FFF, 16'h3FFF, 16'h3FFF);
          else res = rdpq_make(IX_LBLACK, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        end else begin
          if (sum <= GREY_HIGH) res = rdpq_make(IX_LWHITE, 16'hBFFF, 16'hBFFF, 16'hBFFF);
          else res = rdpq_make(IX_WHITE, LVL_FULL, LVL_FULL, LVL_FULL);
        end
      end
    endcase
  end

endmodule

>>> design/rdpq_eight.sv
module rdpq_eight (
  input  logic [15:0]       r,
  input  logic [15:0]       g,
  input  logic [15:0]       b,
  output rdpq_pkg::rdpq_out_t res
);
  import rdpq_pkg::*;

  function automatic logic [2:0] cube_q(logic [15:0] x);
    logic [10:0] t;
    t = {2'b00, x[15:7]} * 11'd3;
    return (t[10:8] > 3'd5) ? 3'd5 : t[10:8];
  endfunction

  logic [15:0] hi, lo, hi_rg, lo_rg, spread;
  logic [17:0] gsum;
  logic [4:0]  gidx;
  logic [7:0]  glvl;
  logic [2:0]  rq, gq, bq;
  logic [7:0]  cube_pix;

  assign hi_rg  = (g > r) ? g : r;
  assign hi     = (b > hi_rg) ? b : hi_rg;
  assign lo_rg  = (g < r) ? g : r;
  assign lo     = (b < lo_rg) ? b : lo_rg;
  assign spread = hi - lo;

  // green counts twice in the grey estimate
  assign gsum = {1'b0, g, 1'b0} + {2'b00, r} + {2'b00, b};
  assign gidx = gsum[17:13];
  assign glvl = {gidx, gidx[4:2]};

  assign rq = cube_q(r);
  assign gq = cube_q(g);
  assign bq = cube_q(b);
  assign cube_pix = CUBE_BASE + ({5'd0, rq} * 8'd36) + ({5'd0, gq} * 8'd6) + {5'd0, bq};

  always_comb begin
    if (spread < GREY_SPREAD) begin
      res = rdpq_make(rdpq_grey_pix(gidx), {glvl, glvl}, {glvl, glvl}, {glvl, glvl});
    end else begin
      res = rdpq_make(cube_pix, rdpq_cube_level(rq), rdpq_cube_level(gq),
                      rdpq_cube_level(bq));
    end
  end

endmodule

>>> design/rdpq_convert.sv
module rdpq_convert (
  input  rdpq_pkg::rdpq_in_t          word,
  input  logic [rdpq_pkg::DepthW-1:0] depth,
  output rdpq_pkg::rdpq_out_t         res
);
  import rdpq_pkg::*;

  logic [15:0] r, g, b;
  logic [17:0] sum;
  rdpq_out_t   four_res, eight_res, packed_res;

  assign r   = word.red_in;
  assign g   = word.green_in;
  assign b   = word.blue_in;
  assign sum = {2'b00, r} + {2'b00, g} + {2'b00, b};

  rdpq_four u_four (
    .r   (r),
    .g   (g),
    .b   (b),
    .sum (sum),
    .res (four_res)
  );

  rdpq_eight u_eight (
    .r   (r),
    .g   (g),
    .b   (b),
    .res (eight_res)
  );

  // packed modes echo the requested color
  always_comb begin
    packed_res.screen_red   = r;
    packed_res.screen_green = g;
    packed_res.screen_blue  = b;
    case (depth)
      MODE_RGB15: packed_res.pixel_value = {8'd0, r[15:11], g[15:11], 1'b0, b[15:11]};
      MODE_RGB16: packed_res.pixel_value = {8'd0, r[15:11], g[15:10], b[15:11]};
      default:    packed_res.pixel_value = {r[15:11], 3'd0, g[15:11], 3'd0, b[15:8]};
    endcase
  end

  always_comb begin
    case (depth)
      MODE_MONO: begin
        if (sum > MONO_THRESH) res = rdpq_make(IX_WHITE, LVL_FULL, LVL_FULL, LVL_FULL);
        else res = rdpq_make(IX_BLACK, LVL_ZERO, LVL_ZERO, LVL_ZERO);
      end
      MODE_FOUR:  res = four_res;
      MODE_EIGHT: res = eight_res;
      default:    res = packed_res;
    endcase
  end

endmodule

>>> design/rgb_to_display_pixel_quantizer_core.sv
// channel   ports                          direction  handshake
// input     in_valid, in_stall, in_data    in         valid / stall
// result    out_valid, out_stall, out_data out        valid / stall
// config    cfg_valid, cfg_ready, cfg_data in         valid / ready, always ready
//
// one word per cycle while the result is not stalled; a taken word passes through the
// input register, conversion logic and result register before it is presented
// synchronous active-low reset empties both registers and sets depth to eight-plane
// a stalled result holds; the input register still fills behind it, so
// in_stall rises only when both registers are occupied
module rgb_to_display_pixel_quantizer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rdpq_pkg::rdpq_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rdpq_pkg::rdpq_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rdpq_pkg::DepthW-1:0]   cfg_data
);
  import rdpq_pkg::*;

  logic              in_vld_r, out_vld_r;
  rdpq_in_t          in_data_r;
  rdpq_out_t         out_data_r;
  logic [DepthW-1:0] depth_r;
  rdpq_out_t         conv_res;
  logic              out_take;

  assign out_take  = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !out_take;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  rdpq_convert u_convert (
    .word  (in_data_r),
    .depth (depth_r),
    .res   (conv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      depth_r   <= MODE_EIGHT;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (out_take) out_vld_r <= in_vld_r;
      if (cfg_valid && cfg_ready) depth_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (out_take && in_vld_r) out_data_r <= conv_res;
  end

endmodule
